>>> sv/accumulator_alu_with_flags_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the accumulator ALU
// Clocked property checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_ALU_WITH_FLAGS_DEFINES_SVH
`define ACCUMULATOR_ALU_WITH_FLAGS_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge, muted while reset is held.
`define ACC_ALU_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: assertion failed");

// Check a property on every rising edge, reset included.
`define ACC_ALU_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("%m: assertion failed");

`else

`define ACC_ALU_ASSERT(label, prop)
`define ACC_ALU_ASSERT_ALWAYS(label, prop)

`endif

`endif

>>> sv/acc_alu_pkg.sv
// ----------------------------------------------------------------------------
// Accumulator ALU package
// Field widths, opcodes and the flag bundle shared by the ALU files.
// ----------------------------------------------------------------------------
package acc_alu_pkg;

    localparam int OPCODE_W  = 5;
    localparam int DATA_W    = 8;
    localparam int WIDE_W    = 16;

    localparam logic [OPCODE_W-1:0] OP_ADD     = 5'd0;
    localparam logic [OPCODE_W-1:0] OP_ADC     = 5'd1;
    localparam logic [OPCODE_W-1:0] OP_SUB     = 5'd2;
    localparam logic [OPCODE_W-1:0] OP_SBB     = 5'd3;
    localparam logic [OPCODE_W-1:0] OP_CMP     = 5'd4;
    localparam logic [OPCODE_W-1:0] OP_AND     = 5'd5;
    localparam logic [OPCODE_W-1:0] OP_XOR     = 5'd6;
    localparam logic [OPCODE_W-1:0] OP_OR      = 5'd7;
    localparam logic [OPCODE_W-1:0] OP_INC     = 5'd8;
    localparam logic [OPCODE_W-1:0] OP_DEC     = 5'd9;
    localparam logic [OPCODE_W-1:0] OP_DAA     = 5'd10;
    localparam logic [OPCODE_W-1:0] OP_RLC     = 5'd11;
    localparam logic [OPCODE_W-1:0] OP_RRC     = 5'd12;
    localparam logic [OPCODE_W-1:0] OP_RAL     = 5'd13;
    localparam logic [OPCODE_W-1:0] OP_RAR     = 5'd14;
    localparam logic [OPCODE_W-1:0] OP_CMA     = 5'd15;
    localparam logic [OPCODE_W-1:0] OP_STC     = 5'd16;
    localparam logic [OPCODE_W-1:0] OP_CMC     = 5'd17;
    localparam logic [OPCODE_W-1:0] OP_DAD     = 5'd18;
    localparam logic [OPCODE_W-1:0] OP_LDA     = 5'd19;
    localparam logic [OPCODE_W-1:0] OP_LHL     = 5'd20;

    typedef struct packed {
        logic s;
        logic z;
        logic ac;
        logic p;
        logic cy;
    } t_flags;

    typedef struct packed {
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] alu_result;
        logic [WIDE_W-1:0] hl;
        t_flags            flags;
    } t_result;

endpackage

>>> sv/acc_alu_intf.sv
// ----------------------------------------------------------------------------
// Accumulator ALU channels
// Valid/ready channels for the operation beat and the result beat.
// ----------------------------------------------------------------------------
interface acc_alu_op_if;
    logic                                valid;
    logic                                ready;
    logic [acc_alu_pkg::OPCODE_W-1:0]    opcode;
    logic [acc_alu_pkg::DATA_W-1:0]      operand;
    logic [acc_alu_pkg::WIDE_W-1:0]      wide_operand;

    modport source (output valid, output opcode, output operand, output wide_operand,
                    input ready);
    modport sink   (input valid, input opcode, input operand, input wide_operand,
                    output ready);
endinterface

interface acc_alu_res_if;
    logic                                valid;
    logic                                ready;
    logic [acc_alu_pkg::DATA_W-1:0]      acc_out;
    logic [acc_alu_pkg::DATA_W-1:0]      alu_result;
    logic [acc_alu_pkg::WIDE_W-1:0]      hl_out;
    logic                                sign_out;
    logic                                zero_out;
    logic                                aux_out;
    logic                                parity_out;
    logic                                carry_out;

    modport source (output valid, output acc_out, output alu_result, output hl_out,
                    output sign_out, output zero_out, output aux_out,
                    output parity_out, output carry_out, input ready);
    modport sink   (input valid, input acc_out, input alu_result, input hl_out,
                    input sign_out, input zero_out, input aux_out,
                    input parity_out, input carry_out, output ready);
endinterface

>>> sv/accumulator_alu_with_flags.sv
// ----------------------------------------------------------------------------
// Accumulator ALU with flags
// 8080-style accumulator, HL pair and S/Z/AC/P/CY flags, one operation a beat.
// ----------------------------------------------------------------------------
// Path: an accepted operation beat enters the input stage, then the result stage.
// Throughput: one operation per cycle unless a full result stage is held by ready;
//   the accumulator, HL and flag registers feed back through the 8/16-bit adds and flag logic.
// Reset (synchronous, active low): clears the accumulator, HL, all flags and
//   both valid stages.
`include "accumulator_alu_with_flags_defines.svh"

module accumulator_alu_with_flags (
    input  logic           i_clk,
    input  logic           i_rst_n,
    acc_alu_op_if.sink     i_op,
    acc_alu_res_if.source  o_res
);

    // input stage
    logic                                r_in_valid;
    logic [acc_alu_pkg::OPCODE_W-1:0]    r_opcode;
    logic [acc_alu_pkg::DATA_W-1:0]      r_operand;
    logic [acc_alu_pkg::WIDE_W-1:0]      r_wide;

    // architectural state
    logic [acc_alu_pkg::DATA_W-1:0]      r_acc, n_acc;
    logic [acc_alu_pkg::WIDE_W-1:0]      r_hl, n_hl;
    acc_alu_pkg::t_flags                 r_flags, n_flags;
    logic [acc_alu_pkg::DATA_W-1:0]      n_alu_result;

    // result stage
    logic                                r_out_valid;
    acc_alu_pkg::t_result                r_res;

    logic                                w_advance;
    logic                                w_exec;

    // arithmetic scratch
    logic                                w_cin;
    logic [acc_alu_pkg::DATA_W:0]        w_sum;
    logic [4:0]                          w_nib;
    logic [acc_alu_pkg::DATA_W-1:0]      w_diff;
    logic [acc_alu_pkg::DATA_W-1:0]      w_res8;
    logic [acc_alu_pkg::WIDE_W:0]        w_dad;
    logic [acc_alu_pkg::DATA_W:0]        w_daa;
    logic                                w_lo_gt9;
    logic                                w_szp;

    assign w_advance = !r_out_valid || o_res.ready;
    assign w_exec    = r_in_valid && w_advance;
    assign i_op.ready = !r_in_valid || w_advance;

    // carry/borrow in from CY only for adc/sbb; add, sub and cmp take no carry in
    assign w_cin  = ((r_opcode == acc_alu_pkg::OP_ADC) || (r_opcode == acc_alu_pkg::OP_SBB))
                    ? r_flags.cy : 1'b0;
    assign w_sum  = {1'b0, r_acc} + {1'b0, r_operand} + {8'd0, w_cin};
    assign w_nib  = {1'b0, r_acc[3:0]} + {1'b0, r_operand[3:0]} + {4'd0, w_cin};
    assign w_diff = r_acc - r_operand - {7'd0, w_cin};
    assign w_dad  = {1'b0, r_hl} + {1'b0, r_wide};
    assign w_lo_gt9 = r_acc[3:0] > 4'd9;

    always_comb begin
        n_acc        = r_acc;
        n_hl         = r_hl;
        n_flags      = r_flags;
        w_res8       = r_acc;
        w_szp        = 1'b0;
        w_daa        = {1'b0, r_acc};
        n_alu_result = r_acc;
        unique case (r_opcode) inside
            acc_alu_pkg::OP_ADD, acc_alu_pkg::OP_ADC: begin
                n_acc      = w_sum[7:0];
                n_flags.cy = w_sum[8];
                n_flags.ac = w_nib[4];
                w_res8     = w_sum[7:0];
                w_szp      = 1'b1;
            end
            acc_alu_pkg::OP_SUB, acc_alu_pkg::OP_SBB, acc_alu_pkg::OP_CMP: begin
                n_flags.cy = ({1'b0, r_operand} + {8'd0, w_cin}) > {1'b0, r_acc};
                n_flags.ac = {1'b0, r_acc[3:0]} >= ({1'b0, r_operand[3:0]} + {4'd0, w_cin});
                w_res8     = w_diff;
                w_szp      = 1'b1;
                if (r_opcode != acc_alu_pkg::OP_CMP) begin
                    n_acc = w_diff;
                end
            end
            acc_alu_pkg::OP_AND: begin
                n_acc      = r_acc & r_operand;
                n_flags.cy = 1'b0;
                n_flags.ac = r_acc[3] | r_operand[3];
                w_res8     = r_acc & r_operand;
                w_szp      = 1'b1;
            end
            acc_alu_pkg::OP_XOR: begin
                n_acc      = r_acc ^ r_operand;
                n_flags.cy = 1'b0;
                n_flags.ac = 1'b0;
                w_res8     = r_acc ^ r_operand;
                w_szp      = 1'b1;
            end
            acc_alu_pkg::OP_OR: begin
                n_acc      = r_acc | r_operand;
                n_flags.cy = 1'b0;
                n_flags.ac = 1'b0;
                w_res8     = r_acc | r_operand;
                w_szp      = 1'b1;
            end
            acc_alu_pkg::OP_INC: begin
                w_res8       = r_operand + 8'd1;
                w_szp        = 1'b1;
                n_flags.ac   = (w_res8[3:0] == 4'h0);
                n_alu_result = w_res8;
            end
            acc_alu_pkg::OP_DEC: begin
                w_res8       = r_operand - 8'd1;
                w_szp        = 1'b1;
                n_flags.ac   = (w_res8[3:0] != 4'hf);
                n_alu_result = w_res8;
            end
            acc_alu_pkg::OP_DAA: begin
                // low digit fixup, then high digit fixup on the adjusted sum
                if (w_lo_gt9 || r_flags.ac) begin
                    w_daa      = w_daa + 9'h006;
                    n_flags.ac = w_lo_gt9;
                end
                if ((w_daa[8:4] > 5'd9) || r_flags.cy) begin
                    w_daa      = w_daa + 9'h060;
                    n_flags.cy = 1'b1;
                end
                n_acc  = w_daa[7:0];
                w_res8 = w_daa[7:0];
                w_szp  = 1'b1;
            end
            acc_alu_pkg::OP_RLC: begin
                n_flags.cy = r_acc[7];
                n_acc      = {r_acc[6:0], r_acc[7]};
            end
            acc_alu_pkg::OP_RRC: begin
                n_flags.cy = r_acc[0];
                n_acc      = {r_acc[0], r_acc[7:1]};
            end
            acc_alu_pkg::OP_RAL: begin
                n_flags.cy = r_acc[7];
                n_acc      = {r_acc[6:0], r_flags.cy};
            end
            acc_alu_pkg::OP_RAR: begin
                n_flags.cy = r_acc[0];
                n_acc      = {r_flags.cy, r_acc[7:1]};
            end
            acc_alu_pkg::OP_CMA: begin
                n_acc = ~r_acc;
            end
            acc_alu_pkg::OP_STC: begin
                n_flags.cy = 1'b1;
            end
            acc_alu_pkg::OP_CMC: begin
                n_flags.cy = ~r_flags.cy;
            end
            acc_alu_pkg::OP_DAD: begin
                n_hl       = w_dad[15:0];
                n_flags.cy = w_dad[16];
            end
            acc_alu_pkg::OP_LDA: begin
                n_acc = r_operand;
            end
            acc_alu_pkg::OP_LHL: begin
                n_hl = r_wide;
            end
            default: begin
                // unused opcodes leave the state alone
            end
        endcase
        if (w_szp) begin
            n_flags.s = w_res8[7];
            n_flags.z = (w_res8 == 8'd0);
            n_flags.p = ~^w_res8;
        end
        if ((r_opcode != acc_alu_pkg::OP_INC) && (r_opcode != acc_alu_pkg::OP_DEC)) begin
            n_alu_result = n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_hl        <= '0;
            r_flags     <= '0;
        end else begin
            if (i_op.ready) begin
                r_in_valid <= i_op.valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_exec) begin
                r_acc   <= n_acc;
                r_hl    <= n_hl;
                r_flags <= n_flags;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_op.valid && i_op.ready) begin
            r_opcode  <= i_op.opcode;
            r_operand <= i_op.operand;
            r_wide    <= i_op.wide_operand;
        end
        if (w_exec) begin
            r_res.acc        <= n_acc;
            r_res.alu_result <= n_alu_result;
            r_res.hl         <= n_hl;
            r_res.flags      <= n_flags;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.acc_out    = r_res.acc;
    assign o_res.alu_result = r_res.alu_result;
    assign o_res.hl_out     = r_res.hl;
    assign o_res.sign_out   = r_res.flags.s;
    assign o_res.zero_out   = r_res.flags.z;
    assign o_res.aux_out    = r_res.flags.ac;
    assign o_res.parity_out = r_res.flags.p;
    assign o_res.carry_out  = r_res.flags.cy;

    // a pending result always mirrors the live state
    `ACC_ALU_ASSERT(a_res_matches_state, r_out_valid |-> (r_res.acc == r_acc && r_res.hl == r_hl && r_res.flags == r_flags))
    // state moves only when a beat executes
    `ACC_ALU_ASSERT(a_state_holds, !w_exec |=> ($stable(r_acc) && $stable(r_hl) && $stable(r_flags)))
    // an executed beat always produces a result beat
    `ACC_ALU_ASSERT(a_exec_gives_result, w_exec |=> r_out_valid)
    // an empty output stage never stalls the input
    `ACC_ALU_ASSERT_ALWAYS(a_no_false_stall, (i_rst_n && !r_out_valid) |-> i_op.ready)

endmodule
